@@ rtl/core/rgss_pkg.sv @@
// ----------------------------------------------------------------------------
// rgss_pkg
// Shared types, widths and signature constants of the return-gadget scanner.
// ----------------------------------------------------------------------------
package rgss_pkg;

  localparam int unsigned CountBitsDefault = 32;
  localparam int unsigned CodeW            = 8;
  localparam int unsigned AddrW            = 64;
  localparam int unsigned ClsW             = 4;
  localparam int unsigned TotalW           = 32;
  localparam int unsigned NumClasses       = 10;
  localparam int unsigned HistBytes        = 3;
  localparam int unsigned HistW            = HistBytes * CodeW;
  localparam int unsigned LimitW           = 5;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 136;

  localparam logic [CodeW-1:0] RetByte = 8'hC3;

  localparam logic [ClsW-1:0] ClsPopRdi  = 4'd0;
  localparam logic [ClsW-1:0] ClsPopRsi  = 4'd1;
  localparam logic [ClsW-1:0] ClsPopRdx  = 4'd2;
  localparam logic [ClsW-1:0] ClsPopRcx  = 4'd3;
  localparam logic [ClsW-1:0] ClsPopRax  = 4'd4;
  localparam logic [ClsW-1:0] ClsSyscall = 4'd5;
  localparam logic [ClsW-1:0] ClsXorRax  = 4'd6;
  localparam logic [ClsW-1:0] ClsXorEax  = 4'd7;
  localparam logic [ClsW-1:0] ClsLeave   = 4'd8;
  localparam logic [ClsW-1:0] ClsOther   = 4'd9;

  typedef struct packed {
    logic            is_return;
    logic [ClsW-1:0] gclass;
    logic [1:0]      back;
  } rgss_match_t;

  function automatic logic [LimitW-1:0] show_limit(input logic [ClsW-1:0] cls);
    logic [LimitW-1:0] lim;
    case (cls)
      ClsPopRdi:            lim = 5'd20;
      ClsPopRsi, ClsPopRdx: lim = 5'd15;
      default:              lim = 5'd10;
    endcase
    return lim;
  endfunction

endpackage

@@ rtl/core/rgss_classify.sv @@
// ----------------------------------------------------------------------------
// rgss_classify
// First-match classification of a return byte against the suffix signatures.
// ----------------------------------------------------------------------------
module rgss_classify
  import rgss_pkg::*;
(
  input  logic [CodeW-1:0] code_byte_i,
  input  logic [HistW-1:0] hist_i,
  input  logic [1:0]       fill_i,
  output rgss_match_t      match_o
);

  logic [CodeW-1:0] h1, h2, h3;
  logic             f1, f2, f3;

  assign h1 = hist_i[7:0];
  assign h2 = hist_i[15:8];
  assign h3 = hist_i[23:16];
  assign f1 = (fill_i >= 2'd1);
  assign f2 = (fill_i >= 2'd2);
  assign f3 = (fill_i == 2'd3);

  always_comb begin
    match_o.is_return = (code_byte_i == RetByte);
    match_o.gclass    = ClsOther;
    match_o.back      = 2'd0;
    if (f1 && h1 == 8'h5F) begin
      match_o.gclass = ClsPopRdi;
      match_o.back   = 2'd1;
    end else if (f1 && h1 == 8'h5E) begin
      match_o.gclass = ClsPopRsi;
      match_o.back   = 2'd1;
    end else if (f1 && h1 == 8'h5A) begin
      match_o.gclass = ClsPopRdx;
      match_o.back   = 2'd1;
    end else if (f1 && h1 == 8'h59) begin
      match_o.gclass = ClsPopRcx;
      match_o.back   = 2'd1;
    end else if (f1 && h1 == 8'h58) begin
      match_o.gclass = ClsPopRax;
      match_o.back   = 2'd1;
    end else if (f2 && h2 == 8'h0F && h1 == 8'h05) begin
      match_o.gclass = ClsSyscall;
      match_o.back   = 2'd2;
    end else if (f3 && h3 == 8'h48 && h2 == 8'h31 && h1 == 8'hC0) begin
      match_o.gclass = ClsXorRax;
      match_o.back   = 2'd3;
    end else if (f2 && h2 == 8'h31 && h1 == 8'hC0) begin
      match_o.gclass = ClsXorEax;
      match_o.back   = 2'd2;
    end else if (f1 && h1 == 8'hC9) begin
      match_o.gclass = ClsLeave;
      match_o.back   = 2'd1;
    end
  end

endmodule

@@ rtl/core/ret_gadget_signature_scanner_core.sv @@
// ----------------------------------------------------------------------------
// ret_gadget_signature_scanner_core
// Classifies return bytes of a code stream and keeps saturating class counts.
// ----------------------------------------------------------------------------
// Path: an accepted input beat is registered in the input register and then
//   in the result register. Throughput: one beat per cycle unless m_axis_tready
//   stalls the result; the classify/count logic sits between the two registers.
// Reset: rst_ni clears history, fill, all counters and both valid flags.
// ----------------------------------------------------------------------------
module ret_gadget_signature_scanner_core
  import rgss_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CountBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] code_byte, [71:8] byte_address
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] section_first
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [3:0] gadget_class, [67:4] gadget_start, [68] report_flag,
  // [100:69] class_total, [132:101] all_total, [135:133] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [0] is_return
  output logic                m_axis_tuser
);

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic              a_valid_q;
  logic [CodeW-1:0]  a_byte_q;
  logic [AddrW-1:0]  a_addr_q;
  logic              a_first_q;

  logic [HistW-1:0]      hist_q;
  logic [1:0]            fill_q;
  logic [COUNT_BITS-1:0] cnt_q [NumClasses];
  logic [COUNT_BITS-1:0] ret_q;

  logic                  m_valid_q;
  logic [OutDataW-1:0]   m_data_q;
  logic                  m_user_q;

  logic                  adv;
  logic [HistW-1:0]      hist_eff;
  logic [1:0]            fill_eff;
  rgss_match_t           match;
  logic [COUNT_BITS-1:0] cnt_cur, cnt_new, ret_new, ret_shown;
  logic [COUNT_BITS+TotalW-1:0] cnt_ext, ret_ext;
  logic [AddrW-1:0]      start;
  logic                  report;
  logic [OutDataW-1:0]   m_data_d;

  assign adv           = a_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !a_valid_q || adv;

  assign hist_eff = a_first_q ? '0 : hist_q;
  assign fill_eff = a_first_q ? 2'd0 : fill_q;

  rgss_classify u_classify (
    .code_byte_i (a_byte_q),
    .hist_i      (hist_eff),
    .fill_i      (fill_eff),
    .match_o     (match)
  );

  assign cnt_cur   = cnt_q[match.gclass];
  assign cnt_new   = (cnt_cur == CountMax) ? cnt_cur : cnt_cur + 1'b1;
  assign ret_new   = (ret_q == CountMax) ? ret_q : ret_q + 1'b1;
  assign ret_shown = match.is_return ? ret_new : ret_q;
  assign cnt_ext   = {{TotalW{1'b0}}, cnt_new};
  assign ret_ext   = {{TotalW{1'b0}}, ret_shown};
  assign start     = a_addr_q - {{(AddrW-2){1'b0}}, match.back};
  assign report    = (match.gclass != ClsOther) &&
                     (cnt_new <= COUNT_BITS'(show_limit(match.gclass)));

  always_comb begin
    m_data_d          = '0;
    m_data_d[132:101] = ret_ext[TotalW-1:0];
    if (match.is_return) begin
      m_data_d[3:0]    = match.gclass;
      m_data_d[67:4]   = start;
      m_data_d[68]     = report;
      m_data_d[100:69] = cnt_ext[TotalW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      a_byte_q  <= s_axis_tdata[7:0];
      a_addr_q  <= s_axis_tdata[71:8];
      a_first_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      fill_q <= 2'd0;
      ret_q  <= '0;
      for (int i = 0; i < NumClasses; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (adv) begin
      hist_q <= {hist_eff[15:0], a_byte_q};
      fill_q <= (fill_eff == 2'd3) ? 2'd3 : fill_eff + 2'd1;
      if (match.is_return) begin
        cnt_q[match.gclass] <= cnt_new;
        ret_q               <= ret_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_data_q <= m_data_d;
      m_user_q <= match.is_return;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

@@ rtl/core/rgss_checker.sv @@
// ----------------------------------------------------------------------------
// rgss_checker
// Port-level checks of the scanner result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rgss_checker
  import rgss_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser
);

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  a_non_return_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[100:0] == '0)
    else $error("non-return beat carries class fields");

  a_class_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= ClsOther && m_axis_tdata[135:133] == '0)
    else $error("class code out of range or padding set");

  a_report_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[68] |->
      m_axis_tuser && m_axis_tdata[3:0] != ClsOther &&
      m_axis_tdata[100:69] != '0 && m_axis_tdata[100:69] <= 32'd20)
    else $error("report flag outside show limit");

endmodule

bind ret_gadget_signature_scanner_core rgss_checker u_rgss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
